FILE: sv/mlpt_pkg.sv
// Shared types, constants and sizing for the multi-level page table walker.
// Used by the datapath, controller, top level and checker.
// Depends on nothing.
package mlpt_pkg;

  // Address and table geometry.
  localparam int ADDR_BITS      = 32;
  localparam int MAX_LEVELS     = 4;
  localparam int MAX_LEVEL_BITS = 8;
  localparam int NODE_POOL      = 64;
  localparam int FRAME_BITS     = 20;
  localparam int BITS_REGS      = 4;

  localparam int LEVEL_LIM   = (MAX_LEVELS < BITS_REGS) ? MAX_LEVELS : BITS_REGS;
  localparam int NODE_SLOTS  = 1 << MAX_LEVEL_BITS;
  localparam int STORE_DEPTH = NODE_POOL * NODE_SLOTS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int STORE_W     = FRAME_BITS + 1;
  localparam int NODE_W      = $clog2(NODE_POOL);
  localparam int CNT_W       = $clog2(NODE_POOL + 1);
  localparam int LVL_W       = $clog2(LEVEL_LIM);
  localparam int TOT_BITS    = MAX_LEVELS * MAX_LEVEL_BITS;
  localparam int CUM_W       = $clog2(TOT_BITS + 1);
  localparam int EXT_W       = ADDR_BITS + TOT_BITS;
  localparam int SH_W        = $clog2(EXT_W + 1);

  // Configuration register widths and indexes.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_LC_W    = 3;
  localparam int CFG_BITS_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3_BITS = 3'd4;

  localparam logic [CFG_LC_W-1:0]   LEVEL_COUNT_RST = 3'd2;
  localparam logic [CFG_BITS_W-1:0] LEVEL_BITS_RST  = 4'd8;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((ADDR_BITS + FRAME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((FRAME_BITS + 7) / 8) * 8;
  localparam int STATUS_W   = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_MISS      = 2'd0,
    ST_HIT       = 2'd1,
    ST_INSERTED  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         clear_step;
    logic         load;
    logic         issue_rd;
    logic         descend;
    logic         alloc;
    logic         leaf_write;
    logic         finish;
    status_code_t code;
  } mlpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic rd_valid;
    logic is_leaf;
    logic is_insert;
    logic pool_full;
    logic out_free;
  } mlpt_sts_t;

endpackage

FILE: sv/mlpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module mlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/mlpt_datapath.sv
// Datapath of the page table walker: configuration registers, walk registers,
// index extraction, entry store, node allocator and result register.
// Depends on mlpt_pkg and mlpt_ram.
module mlpt_datapath
  import mlpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input payload
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result channel
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [STATUS_W-1:0]   out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Controller link
  input  mlpt_cmd_t             cmd,
  output mlpt_sts_t             sts
);

  // Configuration registers.
  logic [CFG_LC_W-1:0]   level_count_r;
  logic [CFG_BITS_W-1:0] level_bits_r [BITS_REGS];

  // Walk registers.
  logic                  op_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic [NODE_W-1:0]     node_r;
  logic [LVL_W-1:0]      level_r;
  logic [CUM_W-1:0]      cum_r;
  logic [STORE_AW-1:0]   sa_r;
  logic [CNT_W-1:0]      next_free_r;
  logic [STORE_AW-1:0]   clr_cnt_r;

  // Result register.
  logic                  out_valid_r;
  status_code_t          res_code_r;
  logic [FRAME_BITS-1:0] res_frame_r;

  // Derived walk values.
  logic [LVL_W-1:0]          last_lvl;
  logic [CFG_BITS_W-1:0]     raw_bits;
  logic [CFG_BITS_W-1:0]     cur_bits;
  logic [CUM_W-1:0]          cum_cur;
  logic [SH_W-1:0]           shift_amt;
  logic [EXT_W-1:0]          ext_addr;
  logic [EXT_W-1:0]          shifted;
  logic [MAX_LEVEL_BITS-1:0] idx_mask;
  logic [MAX_LEVEL_BITS-1:0] slot_idx;
  logic [STORE_AW-1:0]       slot_addr;

  // Store port signals.
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_W-1:0]  wr_data;
  logic [STORE_W-1:0]  rd_data;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      for (int i = 0; i < BITS_REGS; i++) begin
        level_bits_r[i] <= LEVEL_BITS_RST;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEVEL_COUNT: level_count_r   <= cfg_data[CFG_LC_W-1:0];
        CFG_LEVEL0_BITS: level_bits_r[0] <= cfg_data[CFG_BITS_W-1:0];
        CFG_LEVEL1_BITS: level_bits_r[1] <= cfg_data[CFG_BITS_W-1:0];
        CFG_LEVEL2_BITS: level_bits_r[2] <= cfg_data[CFG_BITS_W-1:0];
        CFG_LEVEL3_BITS: level_bits_r[3] <= cfg_data[CFG_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Last level in use: zero counts as one level, large counts saturate.
  always_comb begin
    if (level_count_r == '0) begin
      last_lvl = '0;
    end else if (level_count_r > CFG_LC_W'(LEVEL_LIM)) begin
      last_lvl = LVL_W'(LEVEL_LIM - 1);
    end else begin
      last_lvl = LVL_W'(level_count_r - 1'b1);
    end
  end

  // Index field of the current level, cut from the top of the address.
  always_comb begin
    raw_bits  = level_bits_r[level_r];
    cur_bits  = (raw_bits > CFG_BITS_W'(MAX_LEVEL_BITS)) ?
                CFG_BITS_W'(MAX_LEVEL_BITS) : raw_bits;
    cum_cur   = cum_r + CUM_W'(cur_bits);
    shift_amt = SH_W'(EXT_W) - SH_W'(cum_cur);
    ext_addr  = {addr_r, {TOT_BITS{1'b0}}};
    shifted   = ext_addr >> shift_amt;
    idx_mask  = ~({MAX_LEVEL_BITS{1'b1}} << cur_bits);
    slot_idx  = shifted[MAX_LEVEL_BITS-1:0] & idx_mask;
    slot_addr = {node_r, slot_idx};
  end

  // Walk state: item capture, level step and node allocation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= CNT_W'(1);
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.alloc) begin
        next_free_r <= next_free_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      addr_r  <= in_tdata[ADDR_BITS-1:0];
      frame_r <= in_tdata[ADDR_BITS +: FRAME_BITS];
      node_r  <= '0;
      level_r <= '0;
      cum_r   <= '0;
    end else begin
      if (cmd.issue_rd) begin
        sa_r  <= slot_addr;
        cum_r <= cum_cur;
      end
      if (cmd.descend) begin
        level_r <= level_r + 1'b1;
        node_r  <= cmd.alloc ? next_free_r[NODE_W-1:0] : rd_data[NODE_W-1:0];
      end
    end
  end

  // Store writes: clearing sweep, new inner link, or new leaf frame.
  always_comb begin
    wr_en = cmd.clear_step | cmd.alloc | cmd.leaf_write;
    if (cmd.clear_step) begin
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.alloc) begin
      wr_addr = sa_r;
      wr_data = {1'b1, FRAME_BITS'(next_free_r)};
    end else begin
      wr_addr = sa_r;
      wr_data = {1'b1, frame_r};
    end
  end

  mlpt_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.issue_rd),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  // Result register, held until the consumer takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_code_r <= cmd.code;
      unique case (cmd.code)
        ST_HIT:      res_frame_r <= rd_data[FRAME_BITS-1:0];
        ST_INSERTED: res_frame_r <= frame_r;
        default:     res_frame_r <= '0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_code_r;
  assign out_tdata  = OUT_DATA_W'(res_frame_r);

  // Status toward the controller.
  always_comb begin
    sts.clear_last = (clr_cnt_r == {STORE_AW{1'b1}});
    sts.rd_valid   = rd_data[FRAME_BITS];
    sts.is_leaf    = (level_r == last_lvl);
    sts.is_insert  = op_r;
    sts.pool_full  = (next_free_r >= CNT_W'(NODE_POOL));
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

FILE: sv/mlpt_ctrl.sv
// Controller of the page table walker: clearing sweep, item acceptance and
// the per-level read/evaluate sequence. Depends on mlpt_pkg.
module mlpt_ctrl
  import mlpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  mlpt_sts_t sts,
  output mlpt_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ADDR  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_MISS;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.issue_rd = 1'b1;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.is_leaf) begin
          // Inner level: follow the link, create it, or stop.
          if (sts.rd_valid) begin
            cmd.descend = 1'b1;
            state_nxt   = S_ADDR;
          end else if (sts.is_insert && !sts.pool_full) begin
            cmd.descend = 1'b1;
            cmd.alloc   = 1'b1;
            state_nxt   = S_ADDR;
          end else if (sts.out_free) begin
            cmd.finish = 1'b1;
            cmd.code   = sts.is_insert ? ST_EXHAUSTED : ST_MISS;
            state_nxt  = S_IDLE;
          end
        end else if (sts.out_free) begin
          // Leaf level: report the frame, store a new one, or miss.
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.rd_valid) begin
            cmd.code = ST_HIT;
          end else if (sts.is_insert) begin
            cmd.code       = ST_INSERTED;
            cmd.leaf_write = 1'b1;
          end else begin
            cmd.code = ST_MISS;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: sv/multi_level_page_table_walker.sv
// Multi-level radix page table walker over 32-bit virtual addresses. After
// reset the block sweeps its 16384-entry store, one entry a cycle, and
// accepts no item until the sweep has ended; configuration writes are taken at
// any time. It then works on one item at a time: it accepts the item, then for
// each table level in use reads the entry memory and then checks the entry,
// possibly writing it; a check that finishes the item waits until the output
// register can take the result. Each level reads the entry memory once.
// A finished result sits in an output register, so the next item is taken
// while it waits; a second result waits for that register to empty.
// Depends on mlpt_pkg, mlpt_ctrl, mlpt_datapath and mlpt_ram.
module multi_level_page_table_walker
  import mlpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // virt_addr [31:0], frame_in [51:32]
  input  logic                  in_tuser,   // op: 0 lookup, 1 insert
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // frame_out [19:0]
  output logic [STATUS_W-1:0]   out_tuser   // status [1:0]
);

  mlpt_cmd_t cmd;
  mlpt_sts_t sts;

  assign cfg_ready = 1'b1;

  mlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlpt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: sv/mlpt_checker.sv
// Port-level checker for the page table walker, bound to the top level.
// Depends on mlpt_pkg.
module mlpt_checker
  import mlpt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // The store sweep follows reset, so no request is taken right after it.
  a_no_accept_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) $past(!rst_n) |-> !in_tready)
    else $error("request accepted during store clearing");

  // One item at a time: an accepted beat closes the request side.
  a_one_in_flight: assert property (@(posedge clk)
    disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready)
    else $error("request side open while an item is in progress");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk)
    disable iff (!rst_n) (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result beat changed while stalled");

  // Misses and pool exhaustion carry no frame.
  a_zero_frame: assert property (@(posedge clk)
    disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_MISS || out_tuser == ST_EXHAUSTED)) |->
      (out_tdata == '0))
    else $error("frame reported with a miss or exhausted status");

endmodule

bind multi_level_page_table_walker mlpt_checker u_mlpt_checker (.*);

FILE: tb/sv/tb_multi_level_page_table_walker.sv
// Self-checking testbench for multi_level_page_table_walker: lookups and inserts
// under several table layouts, each result checked against a page table model.
// Depends on mlpt_pkg and the walker RTL.
module tb_multi_level_page_table_walker import mlpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;
  // Register indexes past the last real one; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_LEVEL3_BITS + 3'd1;
  localparam int IDLE_LIMIT   = 50000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    status_code_t          status;
    logic [FRAME_BITS-1:0] frame;
  } walk_result_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Shadow copy of the table layout, entry store and node allocator.
  logic [CFG_LC_W-1:0]   lvl_count_q = LEVEL_COUNT_RST;
  logic [CFG_BITS_W-1:0] lvl_bits_q [BITS_REGS] = '{default: LEVEL_BITS_RST};
  bit                    slot_valid [STORE_DEPTH];
  logic [FRAME_BITS-1:0] slot_data  [STORE_DEPTH];
  int unsigned           free_node = 1;

  walk_result_t          pending_walks [$];
  logic [ADDR_BITS-1:0]  mapped_addrs [$];
  logic [15:0]           prefixes [8] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                                          16'h0000, 16'h0000, 16'h0000, 16'h0000};
  int                    errors = 0;
  int                    n_walks = 0;
  int                    n_layouts = 1;
  int                    status_seen [4] = '{default: 0};
  int                    burst_left = 0;

  rx_mode_t              rx_mode = RX_STEADY;
  int unsigned           rx_left = 0;
  int unsigned           rx_tick = 0;
  int unsigned           quiet_cycles = 0;

  multi_level_page_table_walker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Walk the shadow table for one request, updating it the way the block must.
  function automatic walk_result_t walk_table(logic op, logic [ADDR_BITS-1:0] va,
                                              logic [FRAME_BITS-1:0] fr);
    walk_result_t res;
    int unsigned  levels, width, cum, node, idx, slot;
    res.status = ST_MISS;
    res.frame  = '0;
    levels = (lvl_count_q == 0) ? 1 :
             ((lvl_count_q > LEVEL_LIM) ? LEVEL_LIM : lvl_count_q);
    node = 0;
    cum  = 0;
    for (int lvl = 0; lvl < levels; lvl++) begin
      width = (lvl_bits_q[lvl] > MAX_LEVEL_BITS) ? MAX_LEVEL_BITS : lvl_bits_q[lvl];
      cum += width;
      // Widths are capped at 8 and levels at 4, so cum never passes 32.
      idx  = 32'(64'(va) >> (ADDR_BITS - cum)) & ((32'd1 << width) - 1);
      slot = node * NODE_SLOTS + idx;
      if (lvl + 1 < levels) begin
        if (!slot_valid[slot]) begin
          if (op == OP_LOOKUP) break;
          if (free_node >= NODE_POOL) begin
            // Nodes linked earlier on this walk stay in place.
            res.status = ST_EXHAUSTED;
            break;
          end
          slot_valid[slot] = 1'b1;
          slot_data[slot]  = FRAME_BITS'(free_node);
          free_node++;
        end
        node = slot_data[slot] % NODE_POOL;
      end else if (slot_valid[slot]) begin
        res.status = ST_HIT;
        res.frame  = slot_data[slot];
      end else if (op == OP_INSERT) begin
        slot_valid[slot] = 1'b1;
        slot_data[slot]  = fr;
        res.status = ST_INSERTED;
        res.frame  = fr;
      end
    end
    return res;
  endfunction

  // One configuration beat; the shadow layout follows the accepted write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LEVEL_COUNT) begin
      lvl_count_q = val[CFG_LC_W-1:0];
    end else if (idx >= CFG_LEVEL0_BITS && idx <= CFG_LEVEL3_BITS) begin
      lvl_bits_q[idx - CFG_LEVEL0_BITS] = val;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] b0,
                            input logic [CFG_DATA_W-1:0] b1, input logic [CFG_DATA_W-1:0] b2,
                            input logic [CFG_DATA_W-1:0] b3);
    write_reg(CFG_LEVEL_COUNT, count);
    write_reg(CFG_LEVEL0_BITS, b0);
    write_reg(CFG_LEVEL1_BITS, b1);
    write_reg(CFG_LEVEL2_BITS, b2);
    write_reg(CFG_LEVEL3_BITS, b3);
    n_layouts++;
  endtask

  // Send one request beat, predict its result, then maybe open a gap.
  task automatic send_walk(input logic op, input logic [ADDR_BITS-1:0] va,
                           input logic [FRAME_BITS-1:0] fr);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - ADDR_BITS - FRAME_BITS){1'b0}}, fr, va};
    do @(posedge clk); while (!in_tready);
    pending_walks.push_back(walk_table(op, va, fr));
    n_walks++;
    if (op == OP_INSERT) begin
      if (mapped_addrs.size() >= 48) mapped_addrs.delete($urandom_range(0, 47));
      mapped_addrs.push_back(va);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Random requests. Addresses reuse earlier mappings or draw their top half
  // from a few prefixes so that the node pool lasts; wide ones are fully random.
  task automatic send_random(input int count, input int npfx, input bit wide,
                             input int insert_pct);
    logic                  op;
    logic [ADDR_BITS-1:0]  va;
    logic [FRAME_BITS-1:0] fr;
    repeat (count) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
      if (mapped_addrs.size() != 0 && $urandom_range(0, 99) < 35) begin
        va = mapped_addrs[$urandom_range(0, mapped_addrs.size() - 1)];
      end else if (wide) begin
        va = $urandom;
      end else begin
        va = {prefixes[$urandom_range(0, npfx - 1)], 16'($urandom)};
      end
      case ($urandom_range(0, 9))
        0:       fr = '0;
        1:       fr = '1;
        default: fr = FRAME_BITS'($urandom);
      endcase
      send_walk(op, va, fr);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reset layout, two levels of 8 bits: misses at both levels, inserts,
  // repeated inserts that report the frame already there, extreme values.
  task automatic test_directed_basics();
    send_walk(OP_LOOKUP, 32'h0000_0000, 20'h00000);
    send_walk(OP_INSERT, 32'h0000_0000, 20'hFFFFF);
    send_walk(OP_LOOKUP, 32'h0000_0000, 20'h00000);
    send_walk(OP_INSERT, 32'h0000_0000, 20'h12345);
    send_walk(OP_LOOKUP, 32'h0000_FFFF, 20'hFFFFF);
    send_walk(OP_LOOKUP, 32'h0001_0000, 20'h00000);
    send_walk(OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000);
    send_walk(OP_INSERT, 32'hFFFF_FFFF, 20'h00000);
    send_walk(OP_LOOKUP, 32'hFFFF_0000, 20'hFFFFF);
    send_walk(OP_INSERT, 32'hFF00_0000, 20'hABCDE);
    send_walk(OP_INSERT, 32'h8000_0000, 20'h55555);
    send_walk(OP_INSERT, 32'h7FFF_FFFF, 20'hAAAAA);
    send_walk(OP_LOOKUP, 32'h8000_1234, 20'h00000);
    send_walk(OP_LOOKUP, 32'h7FFF_0000, 20'h00000);
    send_walk(OP_LOOKUP, 32'h8001_0000, 20'h00000);
    wait_idle();
  endtask

  task automatic test_two_level_random();
    send_random(260, 6, 1'b0, 50);
    wait_idle();
  endtask

  // One level over the root, with an oversized width that saturates to 8.
  // Root slots written as pointers earlier now read back as frames.
  task automatic test_single_level_root();
    set_layout(4'd1, 4'd15, 4'd8, 4'd8, 4'd8);
    send_random(180, 8, 1'b0, 50);
    wait_idle();
  endtask

  // A level count whose low bits are zero counts as one level; a zero-width
  // level has a single slot.
  task automatic test_degenerate_levels();
    set_layout(4'd8, 4'd0, 4'd8, 4'd8, 4'd8);
    send_random(40, 8, 1'b0, 50);
    wait_idle();
  endtask

  // Writes to indexes past the register list must leave the layout alone.
  task automatic test_unused_reg_index();
    for (int k = CFG_FIRST_UNUSED; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    send_random(40, 8, 1'b0, 50);
    wait_idle();
  endtask

  task automatic test_four_level_narrow();
    set_layout(4'd4, 4'd1, 4'd1, 4'd1, 4'd1);
    send_random(240, 4, 1'b0, 50);
    wait_idle();
  endtask

  task automatic test_mixed_widths();
    set_layout(4'd3, 4'd3, 4'd0, 4'd5, 4'd1);
    send_random(200, 4, 1'b0, 50);
    wait_idle();
  endtask

  // Level count 7 saturates to four levels; width 15 saturates to 8.
  task automatic test_saturated_count();
    set_layout(4'd7, 4'd2, 4'd15, 4'd1, 4'd3);
    send_random(200, 4, 1'b0, 50);
    wait_idle();
  endtask

  // Full-width random requests, mostly inserts, over four levels of 8 bits drain the pool.
  task automatic test_pool_exhaustion();
    set_layout(4'd4, 4'd8, 4'd8, 4'd8, 4'd8);
    send_random(170, 8, 1'b1, 80);
    wait_idle();
  endtask

  // Receiver: switches among stall patterns, including stall-free stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_STEADY:  out_tready <= 1'b1;
      RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:  out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= ((rx_tick % 32) >= 24);
    endcase
  end

  // Result checker: each result beat against the oldest prediction.
  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser]++;
      if (pending_walks.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d frame %05h",
                 $time, out_tuser, out_tdata[FRAME_BITS-1:0]);
        errors++;
      end else begin
        want = pending_walks.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[FRAME_BITS-1:0] !== want.frame) begin
          $display("%0t: frame_out mismatch, expected %05h, actual %05h",
                   $time, want.frame, out_tdata[FRAME_BITS-1:0]);
          errors++;
        end
      end
    end
  end

  // Watchdog: the limit allows for the post-reset store sweep, which accepts no beat.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 4; k < 8; k++) prefixes[k] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_two_level_random();
    test_single_level_root();
    test_degenerate_levels();
    test_unused_reg_index();
    test_four_level_narrow();
    test_mixed_widths();
    test_saturated_count();
    test_pool_exhaustion();
    wait_idle();
    $display("Ran %0d walks over %0d table layouts, %0d of %0d pool nodes handed out.",
             n_walks, n_layouts, free_node - 1, NODE_POOL - 1);
    $display("Results seen: %0d miss, %0d hit, %0d inserted, %0d pool exhausted.",
             status_seen[ST_MISS], status_seen[ST_HIT], status_seen[ST_INSERTED],
             status_seen[ST_EXHAUSTED]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mlpt_pkg.sv
sv/mlpt_ram.sv
sv/mlpt_datapath.sv
sv/mlpt_ctrl.sv
sv/multi_level_page_table_walker.sv
sv/mlpt_checker.sv
tb/sv/tb_multi_level_page_table_walker.sv
